### rtl/ps2mct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants for the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int unsigned GRID_COLS_DEF   = 80;
  localparam int unsigned GRID_ROWS_DEF   = 25;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ACC_W       = 9;
  localparam int unsigned QMAG_W      = 5;
  localparam int unsigned STEP_SHIFT  = 3;
  localparam int unsigned COL_FIELD_W = 7;
  localparam int unsigned ROW_FIELD_W = 5;

  localparam logic [BYTE_W-1:0] HDR_OVF_MASK = 8'hC0;
  localparam int unsigned       BTN_LEFT     = 0;
  localparam int unsigned       BTN_RIGHT    = 1;

  typedef enum logic [1:0] {
    SLOT_HDR,
    SLOT_DX,
    SLOT_DY,
    SLOT_SCROLL
  } slot_e;

  typedef struct packed {
    logic [1:0]        btn;
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] dy;
  } pkt_t;

  typedef struct packed {
    logic [COL_FIELD_W-1:0] cursor_col;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic                   moved;
    logic                   select_begin;
    logic                   select_done;
    logic [COL_FIELD_W-1:0] start_col;
    logic [ROW_FIELD_W-1:0] start_row;
    logic [COL_FIELD_W-1:0] end_col;
    logic [ROW_FIELD_W-1:0] end_row;
    logic                   paste_request;
  } res_t;

endpackage
`default_nettype wire

### rtl/ps2mct_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_fifo
// Small show-ahead register queue.
// ----------------------------------------------------------------------------
module ps2mct_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ps2mct_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

### rtl/ps2mct_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_front
// Byte assembler: builds four-byte packets and drops overflow headers.
// ----------------------------------------------------------------------------
module ps2mct_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  wire logic [ps2mct_pkg::BYTE_W-1:0]   data_byte_i,
  output logic                                 full_o,
  output logic                                 pkt_push_o,
  output ps2mct_pkg::pkt_t                     pkt_o,
  input  wire logic                            pkt_full_i
);

  ps2mct_pkg::slot_e                 slot_q, slot_d;
  logic [1:0]                        btn_q, btn_d;
  logic [ps2mct_pkg::BYTE_W-1:0]     dx_q, dx_d;
  logic [ps2mct_pkg::BYTE_W-1:0]     dy_q, dy_d;
  logic                              accept;

  assign full_o = (slot_q == ps2mct_pkg::SLOT_SCROLL) && pkt_full_i;
  assign accept = push_i && !full_o;

  assign pkt_o.btn = btn_q;
  assign pkt_o.dx  = dx_q;
  assign pkt_o.dy  = dy_q;

  always_comb begin
    slot_d     = slot_q;
    btn_d      = btn_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    pkt_push_o = 1'b0;
    if (accept) begin
      case (slot_q)
        ps2mct_pkg::SLOT_HDR: begin
          btn_d  = data_byte_i[1:0];
          slot_d = ((data_byte_i & ps2mct_pkg::HDR_OVF_MASK) != '0) ?
                   ps2mct_pkg::SLOT_HDR : ps2mct_pkg::SLOT_DX;
        end
        ps2mct_pkg::SLOT_DX: begin
          dx_d   = data_byte_i;
          slot_d = ps2mct_pkg::SLOT_DY;
        end
        ps2mct_pkg::SLOT_DY: begin
          dy_d   = data_byte_i;
          slot_d = ps2mct_pkg::SLOT_SCROLL;
        end
        ps2mct_pkg::SLOT_SCROLL: begin
          pkt_push_o = 1'b1;
          slot_d     = ps2mct_pkg::SLOT_HDR;
        end
        default: begin
          slot_d = ps2mct_pkg::SLOT_HDR;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= ps2mct_pkg::SLOT_HDR;
    end else begin
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    btn_q <= btn_d;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
  end

endmodule
`default_nettype wire

### rtl/ps2mct_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_back
// Packet executor: button edges, movement accumulation and cursor update.
// ----------------------------------------------------------------------------
module ps2mct_back #(
  parameter int unsigned GRID_COLS = ps2mct_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = ps2mct_pkg::GRID_ROWS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pkt_valid_i,
  input  wire ps2mct_pkg::pkt_t pkt_i,
  output logic                  pkt_pop_o,
  output logic                  res_push_o,
  output ps2mct_pkg::res_t      res_o,
  input  wire logic             res_full_i
);

  localparam int unsigned COL_W  = $clog2(GRID_COLS);
  localparam int unsigned ROW_W  = $clog2(GRID_ROWS);
  localparam int unsigned CSUM_W = ((COL_W > ps2mct_pkg::QMAG_W) ? COL_W : ps2mct_pkg::QMAG_W) + 2;
  localparam int unsigned RSUM_W = ((ROW_W > ps2mct_pkg::QMAG_W) ? ROW_W : ps2mct_pkg::QMAG_W) + 2;
  localparam int unsigned ACC_W  = ps2mct_pkg::ACC_W;

  logic                     left_q, left_d;
  logic                     right_q, right_d;
  logic signed [ACC_W-1:0]  acc_x_q, acc_x_d;
  logic signed [ACC_W-1:0]  acc_y_q, acc_y_d;
  logic [COL_W-1:0]         col_q, col_d;
  logic [ROW_W-1:0]         row_q, row_d;
  logic [COL_W-1:0]         sel_col_q, sel_col_d;
  logic [ROW_W-1:0]         sel_row_q, sel_row_d;

  logic                     fire;
  logic                     btn_l, btn_r;
  logic                     press_l, release_l, press_r;
  logic                     nz;
  logic signed [ACC_W-1:0]  sum_x, sum_y;
  logic                     big_x, big_y;
  logic [ACC_W-1:0]         mag_x, mag_y;
  logic [ps2mct_pkg::QMAG_W-1:0] qmag_x, qmag_y;
  logic signed [CSUM_W-1:0] q_x, new_col;
  logic signed [RSUM_W-1:0] q_y, new_row;
  logic                     ok_col, ok_row;
  logic                     moved;

  assign fire       = pkt_valid_i && !res_full_i;
  assign pkt_pop_o  = fire;
  assign res_push_o = fire;

  assign btn_l     = pkt_i.btn[ps2mct_pkg::BTN_LEFT];
  assign btn_r     = pkt_i.btn[ps2mct_pkg::BTN_RIGHT];
  assign press_l   = btn_l && !left_q;
  assign release_l = !btn_l && left_q;
  assign press_r   = btn_r && !right_q;
  assign nz        = (pkt_i.dx != '0) || (pkt_i.dy != '0);

  // accumulate and take quotient by eight, truncated toward zero
  always_comb begin
    sum_x   = acc_x_q + ACC_W'($signed(pkt_i.dx));
    sum_y   = acc_y_q + ACC_W'($signed(pkt_i.dy));
    big_x   = (sum_x >= ACC_W'(8)) || (sum_x <= -ACC_W'(8));
    big_y   = (sum_y >= ACC_W'(8)) || (sum_y <= -ACC_W'(8));
    mag_x   = sum_x[ACC_W-1] ? -sum_x : sum_x;
    mag_y   = sum_y[ACC_W-1] ? -sum_y : sum_y;
    qmag_x  = ps2mct_pkg::QMAG_W'(mag_x >> ps2mct_pkg::STEP_SHIFT);
    qmag_y  = ps2mct_pkg::QMAG_W'(mag_y >> ps2mct_pkg::STEP_SHIFT);
    q_x     = sum_x[ACC_W-1] ? -$signed(CSUM_W'(qmag_x)) : $signed(CSUM_W'(qmag_x));
    q_y     = sum_y[ACC_W-1] ? -$signed(RSUM_W'(qmag_y)) : $signed(RSUM_W'(qmag_y));
    new_col = $signed(CSUM_W'(col_q)) + q_x;
    new_row = $signed(RSUM_W'(row_q)) - q_y;
    ok_col  = !new_col[CSUM_W-1] && ($unsigned(new_col) <= CSUM_W'(GRID_COLS - 1));
    ok_row  = !new_row[RSUM_W-1] && ($unsigned(new_row) <= RSUM_W'(GRID_ROWS - 1));
  end

  always_comb begin
    left_d    = left_q;
    right_d   = right_q;
    acc_x_d   = acc_x_q;
    acc_y_d   = acc_y_q;
    col_d     = col_q;
    row_d     = row_q;
    sel_col_d = sel_col_q;
    sel_row_d = sel_row_q;
    moved     = 1'b0;
    if (press_l) begin
      sel_col_d = col_q;
      sel_row_d = row_q;
    end
    left_d  = btn_l;
    right_d = btn_r;
    if (nz) begin
      acc_x_d = big_x ? '0 : sum_x;
      acc_y_d = big_y ? '0 : sum_y;
      if (big_x && ok_col) begin
        col_d = new_col[COL_W-1:0];
        moved = 1'b1;
      end
      if (big_y && ok_row) begin
        row_d = new_row[ROW_W-1:0];
        moved = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.cursor_col    = ps2mct_pkg::COL_FIELD_W'(col_d);
    res_o.cursor_row    = ps2mct_pkg::ROW_FIELD_W'(row_d);
    res_o.moved         = moved;
    res_o.select_begin  = press_l;
    res_o.select_done   = release_l;
    res_o.start_col     = ps2mct_pkg::COL_FIELD_W'(sel_col_d);
    res_o.start_row     = ps2mct_pkg::ROW_FIELD_W'(sel_row_d);
    res_o.end_col       = release_l ? ps2mct_pkg::COL_FIELD_W'(col_q) : '0;
    res_o.end_row       = release_l ? ps2mct_pkg::ROW_FIELD_W'(row_q) : '0;
    res_o.paste_request = press_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= 1'b0;
      right_q   <= 1'b0;
      acc_x_q   <= '0;
      acc_y_q   <= '0;
      col_q     <= '0;
      row_q     <= '0;
      sel_col_q <= '0;
      sel_row_q <= '0;
    end else if (fire) begin
      left_q    <= left_d;
      right_q   <= right_d;
      acc_x_q   <= acc_x_d;
      acc_y_q   <= acc_y_d;
      col_q     <= col_d;
      row_q     <= row_d;
      sel_col_q <= sel_col_d;
      sel_row_q <= sel_row_d;
    end
  end

endmodule
`default_nettype wire

### rtl/ps2_mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Mouse byte stream to text cursor, selection and paste events.
// ----------------------------------------------------------------------------
// Takes one mouse byte per cycle while full is low; every fourth byte of a
// packet (header, dx, dy, scroll) yields one result word, which the executor
// pushes once the result queue has room; an overflow header is dropped. The
// assembler, the packet queue, the executor and the result queue each hold
// their own state, so bytes keep flowing while a result waits to be popped;
// full only rises on a scroll byte when the packet queue is also full.
// Results are read from a show-ahead queue of QUEUE_DEPTH words.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker #(
  parameter int unsigned GRID_COLS   = ps2mct_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS   = ps2mct_pkg::GRID_ROWS_DEF,
  parameter int unsigned QUEUE_DEPTH = ps2mct_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic [ps2mct_pkg::BYTE_W-1:0]         data_byte_i,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic [ps2mct_pkg::COL_FIELD_W-1:0]         cursor_col_o,
  output logic [ps2mct_pkg::ROW_FIELD_W-1:0]         cursor_row_o,
  output logic                                       moved_o,
  output logic                                       select_begin_o,
  output logic                                       select_done_o,
  output logic [ps2mct_pkg::COL_FIELD_W-1:0]         start_col_o,
  output logic [ps2mct_pkg::ROW_FIELD_W-1:0]         start_row_o,
  output logic [ps2mct_pkg::COL_FIELD_W-1:0]         end_col_o,
  output logic [ps2mct_pkg::ROW_FIELD_W-1:0]         end_row_o,
  output logic                                       paste_request_o
);

  localparam int unsigned PKT_W = $bits(ps2mct_pkg::pkt_t);
  localparam int unsigned RES_W = $bits(ps2mct_pkg::res_t);

  logic             pkt_push, pkt_full, pkt_empty, pkt_pop;
  ps2mct_pkg::pkt_t pkt_in, pkt_out;
  logic [PKT_W-1:0] pkt_rdata;
  logic             res_push, res_full;
  ps2mct_pkg::res_t res_in, res_out;
  logic [RES_W-1:0] res_rdata;

  ps2mct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .full_o      (full),
    .pkt_push_o  (pkt_push),
    .pkt_o       (pkt_in),
    .pkt_full_i  (pkt_full)
  );

  ps2mct_fifo #(
    .WIDTH (PKT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_pkt_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pkt_push),
    .wdata_i (pkt_in),
    .full_o  (pkt_full),
    .pop_i   (pkt_pop),
    .rdata_o (pkt_rdata),
    .empty_o (pkt_empty)
  );

  assign pkt_out = ps2mct_pkg::pkt_t'(pkt_rdata);

  ps2mct_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (!pkt_empty),
    .pkt_i       (pkt_out),
    .pkt_pop_o   (pkt_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  ps2mct_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out         = ps2mct_pkg::res_t'(res_rdata);
  assign cursor_col_o    = res_out.cursor_col;
  assign cursor_row_o    = res_out.cursor_row;
  assign moved_o         = res_out.moved;
  assign select_begin_o  = res_out.select_begin;
  assign select_done_o   = res_out.select_done;
  assign start_col_o     = res_out.start_col;
  assign start_row_o     = res_out.start_row;
  assign end_col_o       = res_out.end_col;
  assign end_row_o       = res_out.end_row;
  assign paste_request_o = res_out.paste_request;

endmodule
`default_nettype wire
